// File: rtl/mtk_pkg.sv
// shared types, constants and constant tables of the morse tone keyer
// depends on nothing; every other file imports it
package mtk_pkg;

    // phase accumulator, sine table and sample sizes
    localparam int PHASE_BITS      = 16;
    localparam int SINE_TABLE_BITS = 8;
    localparam int SAMPLE_BITS     = 16;
    localparam int TBL_SIZE        = (1 << SINE_TABLE_BITS) + 1;
    localparam int TBL_ADDR_BITS   = SINE_TABLE_BITS + 1;

    // register field widths
    localparam int SPD_BITS       = 16;
    localparam int STEP_BITS      = 15;
    localparam int AMP_BITS       = 15;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CHAR_BITS      = 8;

    // register reset values
    localparam logic [SPD_BITS-1:0]  SPD_RESET  = 16'd2646;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 15'd892;
    localparam logic [AMP_BITS-1:0]  AMP_RESET  = 15'd16383;

    // register indexes on the config port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DOT_SAMPLES = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AMPLITUDE   = 2'd2;

    // item kinds
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // character status codes
    typedef enum logic [1:0] {
        ST_TAKEN       = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_REFUSED     = 2'd2,
        ST_TICK        = 2'd3
    } char_status_t;

    // segment being sent
    typedef enum logic [2:0] {
        SEG_IDLE = 3'b001,
        SEG_TONE = 3'b010,
        SEG_GAP  = 3'b100
    } seg_t;

    // result of the sequencer stage, handed to the scaling stage
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] entry;
        logic                   neg;
        logic                   tone;
        logic                   busy;
        char_status_t           status;
    } mtk_exec_t;

    // morse code of a character
    typedef struct packed {
        logic       valid;
        logic [4:0] pattern;
        logic [2:0] length;
    } mtk_code_t;

    // low 5 bits: elements (bit k = element k, 1 = dash), top 3 bits: length
    typedef logic [7:0] morse_rom_t [36];
    localparam morse_rom_t MORSE_CODES = '{
        8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
        8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
        8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83,
        8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF
    };

    // letters of either case and digits map to a code, anything else is unsupported
    function automatic mtk_code_t morse_lookup(input logic [CHAR_BITS-1:0] ch);
        mtk_code_t  code;
        logic [7:0] off;
        logic [7:0] rom;
        code = '0;
        off  = '0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            off = ch - 8'h41;
            code.valid = 1'b1;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            off = ch - 8'h61;
            code.valid = 1'b1;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            off = ch - 8'h30 + 8'd26;
            code.valid = 1'b1;
        end
        rom = MORSE_CODES[off[5:0]];
        if (code.valid) begin
            code.pattern = rom[4:0];
            code.length  = rom[7:5];
        end
        return code;
    endfunction

    // quarter-wave sine, built at elaboration by a fixed-point taylor series
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    typedef logic [63:0] taylor_div_t [6];
    localparam taylor_div_t TAYLOR_DIVS = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef logic [SAMPLE_BITS-1:0] sine_tbl_t [TBL_SIZE];

    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t   tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] lim;
        lim = 64'd1 << (SAMPLE_BITS - 1);
        for (int i = 0; i < TBL_SIZE; i++) begin
            x  = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int k = 0; k < 6; k++) begin
                q = (x2 * t) >> 30;
                t = ONE_Q30 - q / TAYLOR_DIVS[k];
            end
            s = (x * t) >> 30;
            v = (s + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
            tbl[i] = SAMPLE_BITS'(v > lim ? lim : v);
        end
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage

// File: rtl/mtk_in_if.sv
// input channel of the morse tone keyer: valid/ready plus command payload
// depends on mtk_pkg
interface mtk_in_if;
    import mtk_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [CHAR_BITS-1:0] char_code;

    modport source (output valid, output cmd, output char_code, input ready);
    modport sink   (input valid, input cmd, input char_code, output ready);
endinterface

// File: rtl/mtk_out_if.sv
// result channel of the morse tone keyer: valid/ready plus sample payload
// depends on mtk_pkg
interface mtk_out_if;
    import mtk_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          tone_on;
    logic                          busy_res;
    logic [1:0]                    char_status;

    modport source (output valid, output sample, output tone_on, output busy_res,
                    output char_status, input ready);
    modport sink   (input valid, input sample, input tone_on, input busy_res,
                    input char_status, output ready);
endinterface

// File: rtl/mtk_core.sv
// morse sequencer: keying state, phase accumulator and sine table read
// depends on mtk_pkg
module mtk_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic                             cmd,
    input  logic [mtk_pkg::CHAR_BITS-1:0]    char_code,
    input  logic [mtk_pkg::SPD_BITS-1:0]     dot_samples,
    input  logic [mtk_pkg::STEP_BITS-1:0]    phase_step,
    output mtk_pkg::mtk_exec_t               res
);
    import mtk_pkg::*;

    logic [4:0]             pattern_reg, pattern_next;
    logic [2:0]             length_reg, length_next;
    logic [2:0]             elem_reg, elem_next;
    seg_t                   seg_reg, seg_next;
    logic [2:0]             units_reg, units_next;
    logic [SPD_BITS-1:0]    samples_reg, samples_next;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic                   busy_reg, busy_next;

    logic [SPD_BITS-1:0]      dot_len;
    logic [SPD_BITS-1:0]      samples_dec;
    logic [2:0]               units_dec;
    logic [2:0]               elem_inc;
    logic [7:0]               pattern_ext;
    logic                     cur_dash;
    mtk_code_t                code;
    logic [PHASE_BITS-1:0]    phase_add;
    logic [1:0]               quad;
    logic [SINE_TABLE_BITS-1:0] tbl_idx;
    logic [TBL_ADDR_BITS-1:0] tbl_addr;

    // unit timing helpers
    assign dot_len     = (dot_samples == '0) ? SPD_BITS'(1) : dot_samples;
    assign samples_dec = (samples_reg != '0) ? samples_reg - SPD_BITS'(1) : '0;
    assign units_dec   = (units_reg != '0) ? units_reg - 3'd1 : '0;
    assign elem_inc    = elem_reg + 3'd1;
    assign pattern_ext = {3'b000, pattern_reg};
    assign cur_dash    = pattern_ext[elem_reg];
    assign code        = morse_lookup(char_code);

    // phase advance and quarter-wave table address
    assign phase_add = phase_reg + PHASE_BITS'(phase_step);
    assign quad      = phase_add[PHASE_BITS-1 -: 2];
    assign tbl_idx   = phase_add[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign tbl_addr  = quad[0] ? TBL_ADDR_BITS'(1 << SINE_TABLE_BITS) - {1'b0, tbl_idx}
                               : {1'b0, tbl_idx};

    // next state and result of one item
    always_comb
    begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        elem_next    = elem_reg;
        seg_next     = seg_reg;
        units_next   = units_reg;
        samples_next = samples_reg;
        phase_next   = phase_reg;
        busy_next    = busy_reg;
        res          = '0;
        res.status   = ST_TICK;

        if (cmd == CMD_CHAR)
        begin
            if (busy_reg)
            begin
                res.status = ST_REFUSED;
            end
            else if (char_code == 8'h20)
            begin
                // word space: four silent units
                pattern_next = '0;
                length_next  = '0;
                elem_next    = '0;
                seg_next     = SEG_GAP;
                units_next   = 3'd4;
                samples_next = dot_len;
                busy_next    = 1'b1;
                res.status   = ST_TAKEN;
            end
            else if (code.valid)
            begin
                pattern_next = code.pattern;
                length_next  = code.length;
                elem_next    = '0;
                seg_next     = SEG_TONE;
                units_next   = code.pattern[0] ? 3'd3 : 3'd1;
                samples_next = dot_len;
                busy_next    = 1'b1;
                res.status   = ST_TAKEN;
            end
            else
            begin
                res.status = ST_UNSUPPORTED;
            end
        end
        else if (busy_reg && seg_reg != SEG_IDLE)
        begin
            // tone sample of this tick
            if (seg_reg == SEG_TONE)
            begin
                phase_next = phase_add;
                res.entry  = SINE_TBL[tbl_addr];
                res.neg    = quad[1];
                res.tone   = 1'b1;
            end
            // unit and segment bookkeeping
            if (samples_dec != '0)
            begin
                samples_next = samples_dec;
            end
            else if (units_dec != '0)
            begin
                units_next   = units_dec;
                samples_next = dot_len;
            end
            else if (seg_reg == SEG_TONE)
            begin
                elem_next    = elem_inc;
                seg_next     = SEG_GAP;
                units_next   = (elem_inc < length_reg) ? 3'd1 : 3'd3;
                samples_next = dot_len;
            end
            else if (elem_reg < length_reg)
            begin
                seg_next     = SEG_TONE;
                units_next   = cur_dash ? 3'd3 : 3'd1;
                samples_next = dot_len;
            end
            else
            begin
                pattern_next = '0;
                length_next  = '0;
                elem_next    = '0;
                seg_next     = SEG_IDLE;
                units_next   = '0;
                samples_next = '0;
                busy_next    = 1'b0;
            end
        end
        else
        begin
            // tick while idle
            pattern_next = '0;
            length_next  = '0;
            elem_next    = '0;
            seg_next     = SEG_IDLE;
            units_next   = '0;
            samples_next = '0;
            busy_next    = 1'b0;
        end
        res.busy = busy_next;
    end

    // keying state, updated once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= '0;
            elem_reg    <= '0;
            seg_reg     <= SEG_IDLE;
            units_reg   <= '0;
            samples_reg <= '0;
            phase_reg   <= '0;
            busy_reg    <= 1'b0;
        end
        else if (load)
        begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            elem_reg    <= elem_next;
            seg_reg     <= seg_next;
            units_reg   <= units_next;
            samples_reg <= samples_next;
            phase_reg   <= phase_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

// File: rtl/morse_tone_keyer.sv
// morse tone keyer top level: input register, sequencer, scaling and output register
// depends on mtk_pkg, mtk_in_if, mtk_out_if and mtk_core
//
// usage:
//   in_ch carries items: cmd 0 with char_code starts a character (letters,
//   digits, space) when idle; cmd 1 is one audio sample tick.
//   out_ch returns exactly one result per item, in order: the signed sample,
//   tone_on, busy_res and char_status.
//   the config port writes the dot length, phase_step and amplitude by
//   index on any cycle with cfg_we high; write only while no item is pending.
// pipeline and throughput:
//   a transfer on in_ch passes the input, sequencer and output registers
//   before its result shows on out_ch. one item per cycle sustained while
//   out_ch.ready stays high; each stage holds one item and the
//   sequencer state is updated as the item leaves the input register.
// reset:
//   rst_n clears the keying state to idle, the phase to zero, the
//   registers to their defaults and all stages to empty.
// stalls:
//   when out_ch.ready is low the result is held and the earlier stages
//   keep filling; in_ch.ready drops only once all three stages are full.
module morse_tone_keyer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mtk_in_if.sink                               in_ch,
    mtk_out_if.source                            out_ch,
    input  logic                                 cfg_we,
    input  logic [mtk_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mtk_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import mtk_pkg::*;

    logic [SPD_BITS-1:0]  spd_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [AMP_BITS-1:0]  amp_reg;

    logic                 s1_valid_reg;
    logic                 s1_cmd_reg;
    logic [CHAR_BITS-1:0] s1_char_reg;
    logic                 s2_valid_reg;
    mtk_exec_t            s2_reg;
    mtk_exec_t            exec_next;
    logic                 s3_valid_reg;

    logic                 s1_ok;
    logic                 s2_ok;
    logic                 s3_ok;
    logic                 core_load;

    logic [SAMPLE_BITS+AMP_BITS-1:0] product;
    logic [SAMPLE_BITS-1:0]          magnitude;
    logic signed [SAMPLE_BITS-1:0]   sample_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_reg  <= SPD_RESET;
            step_reg <= STEP_RESET;
            amp_reg  <= AMP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DOT_SAMPLES: spd_reg  <= cfg_data[SPD_BITS-1:0];
                CFG_PHASE_STEP:  step_reg <= cfg_data[STEP_BITS-1:0];
                CFG_AMPLITUDE:   amp_reg  <= cfg_data[AMP_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // per-stage flow control
    assign s3_ok       = !s3_valid_reg || out_ch.ready;
    assign s2_ok       = !s2_valid_reg || s3_ok;
    assign s1_ok       = !s1_valid_reg || s2_ok;
    assign in_ch.ready = s1_ok;
    assign core_load   = s1_valid_reg && s2_ok;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ok)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && s1_ok)
        begin
            s1_cmd_reg  <= in_ch.cmd;
            s1_char_reg <= in_ch.char_code;
        end
    end

    // sequencer
    mtk_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (core_load),
        .cmd         (s1_cmd_reg),
        .char_code   (s1_char_reg),
        .dot_samples (spd_reg),
        .phase_step  (step_reg),
        .res         (exec_next)
    );

    // sequencer result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ok)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (core_load)
            s2_reg <= exec_next;
    end

    // amplitude scaling, truncated toward zero by scaling the magnitude
    assign product     = s2_reg.entry * amp_reg;
    assign magnitude   = product[SAMPLE_BITS-1 +: SAMPLE_BITS];
    assign sample_next = s2_reg.neg ? -$signed(magnitude) : $signed(magnitude);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_ok)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ok)
        begin
            out_ch.sample      <= sample_next;
            out_ch.tone_on     <= s2_reg.tone;
            out_ch.busy_res    <= s2_reg.busy;
            out_ch.char_status <= s2_reg.status;
        end
    end

    assign out_ch.valid = s3_valid_reg;

endmodule

// File: bench/tb_top.sv
// testbench of morse_tone_keyer: directed table, then random items under three idle patterns
// depends on mtk_pkg, mtk_in_if, mtk_out_if and the morse_tone_keyer rtl
// each result is checked against its typed row or a cycle-free model of the keyer held in this module
module tb_top;
    import mtk_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          SEG_ITEMS     = 115;
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;
    localparam logic [7:0]  SPACE_CHAR    = 8'h20;

    // register values after reset
    localparam logic [15:0] DOT_LEN_RST   = 16'd2646;
    localparam logic [14:0] STEP_RST      = 15'd892;
    localparam logic [14:0] AMP_RST       = 15'd16383;

    // sine table generation in q30
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [63:0] UNIT_Q30         = 64'd1 << 30;
    localparam int unsigned TAYLOR_DEN [6]   = '{156, 110, 72, 42, 20, 6};

    // letters then digits: bits 4..0 elements (1 = dash), bits 7..5 element count
    localparam logic [7:0] MORSE_TBL [36] = '{
        8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
        8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
        8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83,
        8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF
    };

    typedef struct packed {
        logic signed [15:0] sample;
        logic               tone_on;
        logic               busy;
        char_status_t       status;
    } keyer_out_t;

    typedef struct packed {
        logic       typed;
        keyer_out_t want;
    } typed_item_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic         cmd;
        logic [7:0]   ch;
        logic [1:0]   reg_idx;
        logic [15:0]  reg_data;
        logic         typed;
        logic         e_busy;
        char_status_t e_status;
    } stim_row_t;

    // directed rows; typed rows carry their result, the rest go to the model
    localparam stim_row_t DIRECTED [25] = '{
        '{ROW_ITEM, CMD_TICK, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_TICK},
        '{ROW_ITEM, CMD_CHAR, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_UNSUPPORTED},
        '{ROW_ITEM, CMD_CHAR, 8'hFF, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_UNSUPPORTED},
        '{ROW_ITEM, CMD_CHAR, 8'h40, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_UNSUPPORTED},
        '{ROW_ITEM, CMD_CHAR, 8'h5B, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_UNSUPPORTED},
        '{ROW_ITEM, CMD_CHAR, 8'h60, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_UNSUPPORTED},
        '{ROW_ITEM, CMD_CHAR, 8'h7B, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_UNSUPPORTED},
        '{ROW_ITEM, CMD_CHAR, 8'h2F, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_UNSUPPORTED},
        '{ROW_ITEM, CMD_CHAR, 8'h3A, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_UNSUPPORTED},
        '{ROW_ITEM, CMD_CHAR, 8'h80, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_UNSUPPORTED},
        '{ROW_CFG,  CMD_CHAR, 8'h00, CFG_UNUSED,      16'hFFFF, 1'b0, 1'b0, ST_TAKEN},
        '{ROW_CFG,  CMD_CHAR, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b0, 1'b0, ST_TAKEN},
        '{ROW_ITEM, CMD_CHAR, 8'h45, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b1, ST_TAKEN},
        '{ROW_ITEM, CMD_CHAR, 8'h71, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b1, ST_REFUSED},
        '{ROW_ITEM, CMD_TICK, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b0, 1'b0, ST_TICK},
        '{ROW_ITEM, CMD_TICK, 8'hFF, CFG_DOT_SAMPLES, 16'h0000, 1'b0, 1'b0, ST_TICK},
        '{ROW_ITEM, CMD_CHAR, 8'h20, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b1, ST_REFUSED},
        '{ROW_ITEM, CMD_TICK, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b0, 1'b0, ST_TICK},
        '{ROW_ITEM, CMD_TICK, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b0, 1'b0, ST_TICK},
        '{ROW_ITEM, CMD_TICK, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b0, ST_TICK},
        '{ROW_ITEM, CMD_CHAR, 8'h20, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b1, ST_TAKEN},
        '{ROW_ITEM, CMD_TICK, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b0, 1'b0, ST_TICK},
        '{ROW_ITEM, CMD_TICK, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b0, 1'b0, ST_TICK},
        '{ROW_ITEM, CMD_TICK, 8'h00, CFG_DOT_SAMPLES, 16'h0000, 1'b0, 1'b0, ST_TICK},
        '{ROW_ITEM, CMD_CHAR, 8'h39, CFG_DOT_SAMPLES, 16'h0000, 1'b1, 1'b1, ST_REFUSED}
    };

    logic clk;
    logic rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    mtk_in_if  in_ch ();
    mtk_out_if out_ch ();

    morse_tone_keyer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // keyer model state and register copies
    logic [4:0]  kp_pattern = '0;
    logic [2:0]  kp_length  = '0;
    logic [2:0]  kp_elem    = '0;
    logic [2:0]  kp_units   = '0;
    seg_t        kp_seg     = SEG_IDLE;
    logic [15:0] kp_left    = '0;
    logic [15:0] tone_phase = '0;
    logic        key_busy   = 1'b0;
    logic [15:0] cfg_spd    = DOT_LEN_RST;
    logic [14:0] cfg_step   = STEP_RST;
    logic [14:0] cfg_amp    = AMP_RST;
    logic [15:0] sine_q [257];

    keyer_out_t  due_q [$];
    typed_item_t typed_q [$];
    int          send_idle;
    int          recv_idle;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // quarter-wave table by truncating taylor series in q30, rounded to 15 fraction bits
    initial
    begin : sine_fill
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        for (int i = 0; i < 257; i++)
        begin
            x  = (QUARTER_TURN_Q30 * 64'(i)) >> 8;
            x2 = (x * x) >> 30;
            t  = UNIT_Q30;
            for (int k = 0; k < 6; k++)
                t = UNIT_Q30 - ((x2 * t) >> 30) / 64'(TAYLOR_DEN[k]);
            s = (x * t) >> 30;
            v = (s + (64'd1 << 14)) >> 15;
            sine_q[i] = (v > 64'd32768) ? 16'h8000 : v[15:0];
        end
    end

    function automatic logic [15:0] dot_len();
        return (cfg_spd == 16'd0) ? 16'd1 : cfg_spd;
    endfunction

    function automatic void start_tone();
        kp_seg   = SEG_TONE;
        kp_units = ((kp_pattern >> kp_elem) & 5'd1) != 5'd0 ? 3'd3 : 3'd1;
        kp_left  = dot_len();
    endfunction

    function automatic void clear_keying();
        kp_pattern = '0;
        kp_length  = '0;
        kp_elem    = '0;
        kp_seg     = SEG_IDLE;
        kp_units   = '0;
        kp_left    = '0;
        key_busy   = 1'b0;
    endfunction

    // advance the keyer by one item and return its result
    function automatic keyer_out_t keyer_step(input logic c, input logic [7:0] ch);
        keyer_out_t  r;
        logic [1:0]  quad;
        logic [8:0]  ix;
        logic [31:0] mag;
        logic [5:0]  code_ix;
        logic        known;
        r = '0;
        if (c == CMD_CHAR)
        begin
            known   = 1'b1;
            code_ix = '0;
            if (ch >= 8'h41 && ch <= 8'h5A)
                code_ix = 6'(ch - 8'h41);
            else if (ch >= 8'h61 && ch <= 8'h7A)
                code_ix = 6'(ch - 8'h61);
            else if (ch >= 8'h30 && ch <= 8'h39)
                code_ix = 6'(ch - 8'h30) + 6'd26;
            else
                known = 1'b0;
            if (key_busy)
                r.status = ST_REFUSED;
            else if (ch == SPACE_CHAR)
            begin
                // word space: four units of silence
                clear_keying();
                kp_seg   = SEG_GAP;
                kp_units = 3'd4;
                kp_left  = dot_len();
                key_busy = 1'b1;
                r.status = ST_TAKEN;
            end
            else if (!known)
                r.status = ST_UNSUPPORTED;
            else
            begin
                kp_pattern = MORSE_TBL[code_ix][4:0];
                kp_length  = MORSE_TBL[code_ix][7:5];
                kp_elem    = '0;
                key_busy   = 1'b1;
                start_tone();
                r.status = ST_TAKEN;
            end
        end
        else
        begin
            r.status = ST_TICK;
            if (key_busy && kp_seg != SEG_IDLE)
            begin
                // tone sample: step the phase, then mirror and sign by quadrant
                if (kp_seg == SEG_TONE)
                begin
                    tone_phase = tone_phase + 16'(cfg_step);
                    quad = tone_phase[15:14];
                    ix   = {1'b0, tone_phase[13:6]};
                    if (quad[0])
                        ix = 9'd256 - ix;
                    mag = (32'(sine_q[ix]) * 32'(cfg_amp)) >> 15;
                    r.sample  = quad[1] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
                    r.tone_on = 1'b1;
                end
                // unit and segment bookkeeping
                if (kp_left != 16'd0)
                    kp_left = kp_left - 16'd1;
                if (kp_left == 16'd0)
                begin
                    if (kp_units != 3'd0)
                        kp_units = kp_units - 3'd1;
                    if (kp_units != 3'd0)
                        kp_left = dot_len();
                    else if (kp_seg == SEG_TONE)
                    begin
                        kp_elem  = kp_elem + 3'd1;
                        kp_seg   = SEG_GAP;
                        kp_units = (kp_elem < kp_length) ? 3'd1 : 3'd3;
                        kp_left  = dot_len();
                    end
                    else if (kp_elem < kp_length)
                        start_tone();
                    else
                        clear_keying();
                end
            end
            else
                clear_keying();
        end
        r.busy = key_busy;
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("mismatch in %s: got %0d, want %0d (cycle %0d)", what, got, want,
                     cycle_count);
        mismatches++;
    endtask

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle);

    // register writes, input transfers into the model, result transfers against it
    always @(posedge clk)
    begin : monitor
        typed_item_t ti;
        keyer_out_t  got;
        keyer_out_t  want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DOT_SAMPLES: cfg_spd  = cfg_data;
                    CFG_PHASE_STEP:  cfg_step = cfg_data[14:0];
                    CFG_AMPLITUDE:   cfg_amp  = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                ti  = typed_q.pop_front();
                got = keyer_step(in_ch.cmd, in_ch.char_code);
                due_q.push_back(ti.typed ? ti.want : got);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_q.size() == 0)
                    report("result with nothing due, status", int'(out_ch.char_status), -1);
                else
                begin
                    want = due_q.pop_front();
                    if (out_ch.sample !== want.sample)
                        report("sample", out_ch.sample, want.sample);
                    if (out_ch.tone_on !== want.tone_on)
                        report("tone_on", out_ch.tone_on, want.tone_on);
                    if (out_ch.busy_res !== want.busy)
                        report("busy_res", out_ch.busy_res, want.busy);
                    if (out_ch.char_status !== want.status)
                        report("char_status", out_ch.char_status, want.status);
                end
            end
        end
    end

    // one input transfer; entered and left at a falling edge
    task automatic send_item(input logic c, input logic [7:0] ch, input logic typed,
                             input keyer_out_t want);
        typed_item_t ti;
        ti.typed = typed;
        ti.want  = want;
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= c;
        in_ch.char_code <= ch;
        typed_q.push_back(ti);
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    // stop sending and wait until every result is back
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (due_q.size() != 0 || typed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // one register write, followed by a wait with cfg_we low
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        stim_row_t  row;
        keyer_out_t want;
        int         counted;
        int         pick;
        logic [7:0] ch;

        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_TICK;
        in_ch.char_code = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        send_idle       = 37;
        recv_idle       = 81;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_reg(row.reg_idx, row.reg_data);
            end
            else
            begin
                want         = '0;
                want.busy    = row.e_busy;
                want.status  = row.e_status;
                send_item(row.cmd, row.ch, row.typed, want);
            end
        end

        // random segments, each under its own register setting
        for (int s = 0; s < 5; s++)
        begin
            if (s == 2)
            begin
                send_idle = 81;
                recv_idle = 37;
            end
            else if (s == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (s > 0)
            begin
                settle();
                case (s)
                    1:
                    begin
                        write_reg(CFG_DOT_SAMPLES, 16'd2);
                        write_reg(CFG_PHASE_STEP, 16'hFFFF);
                        write_reg(CFG_AMPLITUDE, 16'hFFFF);
                    end
                    2:
                    begin
                        write_reg(CFG_DOT_SAMPLES, 16'd1);
                        write_reg(CFG_PHASE_STEP, 16'h0000);
                        write_reg(CFG_AMPLITUDE, 16'h0000);
                    end
                    3:
                    begin
                        write_reg(CFG_DOT_SAMPLES, 16'd3);
                        write_reg(CFG_PHASE_STEP, 16'($urandom_range(65535)));
                        write_reg(CFG_AMPLITUDE, 16'($urandom_range(65535)));
                    end
                    default:
                    begin
                        write_reg(CFG_DOT_SAMPLES, 16'($urandom_range(4, 1)));
                        write_reg(CFG_PHASE_STEP, 16'($urandom_range(65535)));
                        write_reg(CFG_AMPLITUDE, 16'($urandom_range(65535)));
                    end
                endcase
            end
            counted = 0;
            while (counted < SEG_ITEMS)
            begin
                pick = $urandom_range(99);
                if (key_busy)
                begin
                    // mostly ticks; a few characters that must be refused
                    if (pick < 4)
                        send_item(CMD_CHAR, 8'($urandom_range(255)), 1'b0, '0);
                    else
                    begin
                        send_tick();
                        counted++;
                    end
                end
                else if (pick < 12)
                begin
                    send_tick();
                    counted++;
                end
                else if (pick < 22)
                    send_item(CMD_CHAR, 8'($urandom_range(255)), 1'b0, '0);
                else
                begin
                    // a supported character: letter of either case, digit or space
                    pick = $urandom_range(62);
                    if (pick < 26)
                        ch = 8'h41 + 8'(pick);
                    else if (pick < 52)
                        ch = 8'h61 + 8'(pick - 26);
                    else if (pick < 62)
                        ch = 8'h30 + 8'(pick - 52);
                    else
                        ch = SPACE_CHAR;
                    send_item(CMD_CHAR, ch, 1'b0, '0);
                    counted++;
                end
            end
        end

        // longest dot unit; the run ends while its tone is still sounding
        while (key_busy)
            send_tick();
        settle();
        write_reg(CFG_DOT_SAMPLES, 16'hFFFF);
        want        = '0;
        want.busy   = 1'b1;
        want.status = ST_TAKEN;
        send_item(CMD_CHAR, 8'h45, 1'b1, want);
        repeat (20) send_tick();
        settle();

        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
